@@ hdl/olist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Sizes, operation and status codes, the cell command bundle and the value
// conversions shared by the list cells and the top level.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW         = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_INS_HEAD  = 3'd0;
	localparam logic [2:0] OP_INS_TAIL  = 3'd1;
	localparam logic [2:0] OP_INS_AT    = 3'd2;
	localparam logic [2:0] OP_DELETE    = 3'd3;
	localparam logic [2:0] OP_SEARCH    = 3'd4;
	localparam logic [2:0] OP_WALK_FWD  = 3'd5;
	localparam logic [2:0] OP_WALK_BACK = 3'd6;
	localparam logic [2:0] OP_CLEAR     = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_BAD_POS   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic                  ins_en;
		logic                  del_en;
		logic [IW-1:0]         pos;
		logic [DATA_WIDTH-1:0] din;
		logic                  cmp_en;
		logic [DATA_WIDTH-1:0] key;
		logic [CW-1:0]         count;
	} cell_cmd_t;

	function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_elem(input logic [DATA_WIDTH-1:0] d);
		logic signed [63:0] w;
		w = 64'(signed'(d));
		return w[31:0];
	endfunction

endpackage

@@ hdl/ordered_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one operation per transfer (opcode, value,
// position). The output channel carries result transfers (status, index,
// element, last, occupancy); every operation gives one result, except a walk
// of a non-empty list, which gives one result per entry with last on the
// final one.
// At the transfer edge every cell compares its entry with the value. Once the
// output register is free, the first hit is chosen, the cells shift or load in
// parallel and the result enters the output register; the input stays stalled
// until the operation's last result has been loaded. A walk then sends one
// entry per cycle, read from the cells by index, unless the receiver stalls.
// While the receiver stalls, the output register holds its result, and the
// engine waits without changing the list and stalls any further operation.
// Reset empties the list and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] value,
	input  logic [6:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [5:0]         index,
	output logic signed [31:0] element,
	output logic               last,
	output logic [6:0]         occupancy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	localparam int DEPTH = olist_pkg::DEPTH;
	localparam int DW    = olist_pkg::DATA_WIDTH;
	localparam int IW    = olist_pkg::IW;
	localparam int CW    = olist_pkg::CW;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] wk_q;
	logic [2:0]    op_s1;
	logic [DW-1:0] data_s1;
	logic [6:0]    pos_s1;

	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [5:0]         index_q;
	logic signed [31:0] element_q;
	logic               last_q;
	logic [6:0]         occupancy_q;

	olist_pkg::cell_cmd_t cmd;
	logic [DW-1:0]        cell_data [DEPTH];
	logic [DW-1:0]        left_d    [DEPTH];
	logic [DW-1:0]        right_d   [DEPTH];
	logic [DEPTH-1:0]     hits;

	logic          accept;
	logic          out_free;
	logic          exec_fire;
	logic          walk_fire;
	logic          full;
	logic          empty;
	logic          any_hit;
	logic [IW-1:0] hit_idx;
	logic [2:0]    ex_status;
	logic          do_ins;
	logic          do_del;
	logic [IW-1:0] ex_pos;
	logic [CW-1:0] nxt_cnt;
	logic [5:0]    ex_index;
	logic          go_walk;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] rd_idx;
	logic          wk_last;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exec_fire = (state_q == S_EXEC) && out_free;
	assign walk_fire = (state_q == S_WALK) && out_free;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				any_hit = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	always_comb begin
		ex_status = olist_pkg::ST_OK;
		do_ins    = 1'b0;
		do_del    = 1'b0;
		ex_pos    = '0;
		nxt_cnt   = count_q;
		ex_index  = '0;
		go_walk   = 1'b0;
		case (op_s1)
			olist_pkg::OP_INS_HEAD: begin
				if (full) begin
					ex_status = olist_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			olist_pkg::OP_INS_TAIL: begin
				if (empty) begin
					ex_status = olist_pkg::ST_EMPTY;
				end else if (full) begin
					ex_status = olist_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					ex_pos = count_q[IW-1:0];
				end
			end
			olist_pkg::OP_INS_AT: begin
				if (pos_s1 == 7'd0) begin
					if (full) begin
						ex_status = olist_pkg::ST_FULL;
					end else begin
						do_ins = 1'b1;
					end
				end else if (empty) begin
					ex_status = olist_pkg::ST_EMPTY;
				end else if (8'(pos_s1) > 8'(count_q)) begin
					ex_status = olist_pkg::ST_BAD_POS;
				end else if (full) begin
					ex_status = olist_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					ex_pos = pos_s1[IW-1:0];
				end
			end
			olist_pkg::OP_DELETE: begin
				if (empty) begin
					ex_status = olist_pkg::ST_EMPTY;
				end else if (!any_hit) begin
					ex_status = olist_pkg::ST_NOT_FOUND;
				end else begin
					do_del = 1'b1;
					ex_pos = hit_idx;
				end
			end
			olist_pkg::OP_SEARCH: begin
				if (empty) begin
					ex_status = olist_pkg::ST_EMPTY;
				end else if (!any_hit) begin
					ex_status = olist_pkg::ST_NOT_FOUND;
				end else begin
					ex_index = 6'(hit_idx);
				end
			end
			olist_pkg::OP_WALK_FWD, olist_pkg::OP_WALK_BACK: begin
				if (empty) begin
					ex_status = olist_pkg::ST_EMPTY;
				end else begin
					go_walk = 1'b1;
				end
			end
			olist_pkg::OP_CLEAR: begin
				nxt_cnt = '0;
			end
			default: begin
				ex_status = olist_pkg::ST_OK;
			end
		endcase
		if (do_ins) begin
			nxt_cnt = CW'(count_q + 1'b1);
		end else if (do_del) begin
			nxt_cnt = CW'(count_q - 1'b1);
		end
	end

	assign last_idx = IW'(count_q - 1'b1);
	assign rd_idx   = (op_s1 == olist_pkg::OP_WALK_FWD) ? wk_q : IW'(last_idx - wk_q);
	assign wk_last  = (wk_q == last_idx);

	always_comb begin
		cmd.ins_en = exec_fire && do_ins;
		cmd.del_en = exec_fire && do_del;
		cmd.pos    = ex_pos;
		cmd.din    = data_s1;
		cmd.cmp_en = accept;
		cmd.key    = olist_pkg::to_data(value);
		cmd.count  = count_q;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign left_d[g] = data_s1;
		end else begin : g_mid
			assign left_d[g] = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_d[g] = cell_data[g];
		end else begin : g_body
			assign right_d[g] = cell_data[g+1];
		end
		olist_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IW'(g)),
			.cmd     (cmd),
			.left_d  (left_d[g]),
			.right_d (right_d[g]),
			.data    (cell_data[g]),
			.hit     (hits[g])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			data_s1 <= olist_pkg::to_data(value);
			pos_s1  <= position;
		end
		if (exec_fire) begin
			status_q    <= ex_status;
			index_q     <= go_walk ? 6'(op_s1 == olist_pkg::OP_WALK_FWD ? '0 : last_idx)
			                       : ex_index;
			element_q   <= go_walk ? olist_pkg::to_elem(
			                             cell_data[op_s1 == olist_pkg::OP_WALK_FWD ? '0 : last_idx])
			                       : '0;
			last_q      <= go_walk ? (count_q == CW'(1)) : 1'b1;
			occupancy_q <= 7'(nxt_cnt);
		end else if (walk_fire) begin
			status_q    <= olist_pkg::ST_OK;
			index_q     <= 6'(rd_idx);
			element_q   <= olist_pkg::to_elem(cell_data[rd_idx]);
			last_q      <= wk_last;
			occupancy_q <= 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire || walk_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						count_q <= nxt_cnt;
						wk_q    <= IW'(1);
						if (go_walk && count_q != CW'(1)) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WALK: begin
					if (walk_fire) begin
						wk_q <= IW'(wk_q + 1'b1);
						if (wk_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign element   = element_q;
	assign last      = last_q;
	assign occupancy = occupancy_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above list depth");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> count_q != '0)
		else $error("walk running on an empty list");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != olist_pkg::ST_OK |-> last_q)
		else $error("error result not marked last");

	a_edit_count: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && (do_ins || do_del) |=> count_q != $past(count_q))
		else $error("edit left the entry count unchanged");
`endif

endmodule

@@ hdl/olist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, shifts toward the tail on insert and toward the head
// on delete, and compares its entry against the search key.
// ----------------------------------------------------------------------------
module olist_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [olist_pkg::IW-1:0]        idx,
	input  olist_pkg::cell_cmd_t            cmd,
	input  logic [olist_pkg::DATA_WIDTH-1:0] left_d,
	input  logic [olist_pkg::DATA_WIDTH-1:0] right_d,
	output logic [olist_pkg::DATA_WIDTH-1:0] data,
	output logic                            hit
);

	logic [olist_pkg::DATA_WIDTH-1:0] data_q;
	logic                             hit_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (idx == cmd.pos) begin
				data_q <= cmd.din;
			end else if (idx > cmd.pos) begin
				data_q <= left_d;
			end
		end else if (cmd.del_en && idx >= cmd.pos) begin
			data_q <= right_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.cmp_en) begin
			hit_q <= (olist_pkg::CW'(idx) < cmd.count) && (data_q == cmd.key);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

@@ dv/ordered_list_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Sends list operations over the input channel and keeps its own queue-based
// copy of the list to predict every result transfer. Results are checked in
// order, field by field. A directed pass covers the empty and full cases and
// the position rules. Random traffic then runs under changing idle patterns,
// a long receiver hold-off and a pause that lets the engine drain.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;

	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  index;
		logic [31:0] element;
		logic        last;
		logic [6:0]  occupancy;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         opcode;
	logic signed [31:0] value;
	logic [6:0]         position;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [5:0]         index;
	logic signed [31:0] element;
	logic               last;
	logic [6:0]         occupancy;

	logic [olist_pkg::DATA_WIDTH-1:0] list_cells[$];
	list_result_t                     expected_results[$];
	int                               failures      = 0;
	int                               src_idle_pct  = 0;
	int                               sink_idle_pct = 0;
	int                               hold_off_left = 0;
	int                               quiet_cycles  = 0;

	ordered_list_engine u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [olist_pkg::DATA_WIDTH-1:0] value_to_cell(
			input logic signed [31:0] v);
		logic signed [63:0] w;
		w = v;
		return w[olist_pkg::DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] cell_to_element(
			input logic [olist_pkg::DATA_WIDTH-1:0] d);
		logic signed [63:0] w;
		w = 64'(d) << (64 - olist_pkg::DATA_WIDTH);
		w = w >>> (64 - olist_pkg::DATA_WIDTH);
		return w[31:0];
	endfunction

	function automatic logic [2:0] insert_cell(input int at,
			input logic [olist_pkg::DATA_WIDTH-1:0] d);
		if (list_cells.size() >= olist_pkg::DEPTH)
			return olist_pkg::ST_FULL;
		list_cells.insert(at, d);
		return olist_pkg::ST_OK;
	endfunction

	// Updates the list copy for one accepted operation and queues its results.
	function automatic void apply_list_op(input logic [2:0] op, input logic signed [31:0] v,
			input logic [6:0] pos);
		logic [olist_pkg::DATA_WIDTH-1:0] d;
		list_result_t                     r;
		int                               n;
		int                               hit;
		int                               e;
		d   = value_to_cell(v);
		n   = list_cells.size();
		r   = '0;
		hit = -1;
		if ((op == olist_pkg::OP_WALK_FWD || op == olist_pkg::OP_WALK_BACK) && n > 0) begin
			for (int i = 0; i < n; i++) begin
				e           = (op == olist_pkg::OP_WALK_FWD) ? i : n - 1 - i;
				r.status    = olist_pkg::ST_OK;
				r.index     = 6'(e);
				r.element   = cell_to_element(list_cells[e]);
				r.last      = (i == n - 1);
				r.occupancy = 7'(n);
				expected_results.push_back(r);
			end
			return;
		end
		r.status = olist_pkg::ST_OK;
		case (op)
			olist_pkg::OP_INS_HEAD: begin
				r.status = insert_cell(0, d);
			end
			olist_pkg::OP_INS_TAIL: begin
				r.status = (n == 0) ? olist_pkg::ST_EMPTY : insert_cell(n, d);
			end
			olist_pkg::OP_INS_AT: begin
				if (pos == 0)
					r.status = insert_cell(0, d);
				else if (n == 0)
					r.status = olist_pkg::ST_EMPTY;
				else if (pos > n)
					r.status = olist_pkg::ST_BAD_POS;
				else
					r.status = insert_cell(pos, d);
			end
			olist_pkg::OP_DELETE, olist_pkg::OP_SEARCH: begin
				if (n == 0) begin
					r.status = olist_pkg::ST_EMPTY;
				end else begin
					for (int i = n - 1; i >= 0; i--)
						if (list_cells[i] == d)
							hit = i;
					if (hit < 0)
						r.status = olist_pkg::ST_NOT_FOUND;
					else if (op == olist_pkg::OP_DELETE)
						list_cells.delete(hit);
					else
						r.index = 6'(hit);
				end
			end
			olist_pkg::OP_WALK_FWD, olist_pkg::OP_WALK_BACK: begin
				r.status = olist_pkg::ST_EMPTY;
			end
			olist_pkg::OP_CLEAR: begin
				list_cells.delete();
			end
			default: begin
			end
		endcase
		r.last      = 1'b1;
		r.occupancy = 7'(list_cells.size());
		expected_results.push_back(r);
	endfunction

	task automatic send_op(input logic [2:0] op, input logic signed [31:0] v,
			input logic [6:0] pos);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		position <= pos;
		do @(posedge clk); while (in_stall);
		apply_list_op(op, v, pos);
	endtask

	task automatic send_random_op();
		logic [2:0]         op;
		logic signed [31:0] v;
		logic [6:0]         pos;
		int                 k;
		k = $urandom_range(99);
		if (k < 16)
			op = olist_pkg::OP_INS_HEAD;
		else if (k < 32)
			op = olist_pkg::OP_INS_TAIL;
		else if (k < 52)
			op = olist_pkg::OP_INS_AT;
		else if (k < 68)
			op = olist_pkg::OP_DELETE;
		else if (k < 82)
			op = olist_pkg::OP_SEARCH;
		else if (k < 90)
			op = olist_pkg::OP_WALK_FWD;
		else if (k < 98)
			op = olist_pkg::OP_WALK_BACK;
		else
			op = olist_pkg::OP_CLEAR;
		k = $urandom_range(99);
		if (k < 30 && list_cells.size() > 0) begin
			v = cell_to_element(list_cells[$urandom_range(list_cells.size() - 1)]);
		end else if (k < 70) begin
			case ($urandom_range(7))
				0: v = 32'sh7FFF_FFFF;
				1: v = 32'sh8000_0000;
				2: v = 0;
				3: v = -1;
				4: v = 1;
				5: v = 42;
				6: v = -1000;
				default: v = 7;
			endcase
		end else begin
			v = $urandom;
		end
		if ($urandom_range(99) < 75)
			pos = 7'($urandom_range(list_cells.size() + 1));
		else
			pos = 7'($urandom_range(127));
		send_op(op, v, pos);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_op(olist_pkg::OP_INS_TAIL, 5, 0);
		send_op(olist_pkg::OP_INS_AT, 9, 5);
		send_op(olist_pkg::OP_WALK_FWD, 0, 0);
		send_op(olist_pkg::OP_DELETE, 0, 0);
		send_op(olist_pkg::OP_SEARCH, 0, 0);
		send_op(olist_pkg::OP_INS_AT, 32'sh7FFF_FFFF, 0);
		send_op(olist_pkg::OP_INS_HEAD, 32'sh8000_0000, 0);
		send_op(olist_pkg::OP_INS_AT, 0, 2);
		send_op(olist_pkg::OP_INS_AT, 11, 127);
		send_op(olist_pkg::OP_INS_TAIL, -1, 0);
		for (int i = 0; i < 12; i++)
			send_op(olist_pkg::OP_INS_AT, i * 1000 + 3, 7'(list_cells.size() / 2));
		send_op(olist_pkg::OP_INS_TAIL, 13, 0);
		send_op(olist_pkg::OP_INS_AT, 14, 7'(olist_pkg::DEPTH));
		send_op(olist_pkg::OP_INS_AT, 15, 127);
		send_op(olist_pkg::OP_WALK_BACK, 0, 0);
		send_op(olist_pkg::OP_SEARCH, 0, 0);
		send_op(olist_pkg::OP_SEARCH, 32'sh5A5A_0F0F, 0);
		send_op(olist_pkg::OP_DELETE, 32'sh8000_0000, 0);
		send_op(olist_pkg::OP_CLEAR, 0, 0);
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_random_op();
	endtask

	// The receiver holds off long enough for the engine to fill and stall its input.
	task automatic test_backpressure();
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (24)
			send_random_op();
	endtask

	task automatic test_drain_pause();
		repeat (5)
			send_random_op();
		wait_for_drain();
		repeat (5)
			send_random_op();
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else begin
				out_stall <= ($urandom_range(99) < sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("Result transfer with no expected result: status %0d index %0d",
					status, index);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					failures++;
				end
				if (index !== want.index) begin
					$error("index: expected %0d, actual %0d", want.index, index);
					failures++;
				end
				if (element !== want.element) begin
					$error("element: expected %0d, actual %0d", $signed(want.element),
						element);
					failures++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					failures++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy,
						occupancy);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ordered_list_engine_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		opcode   = olist_pkg::OP_INS_HEAD;
		value    = '0;
		position = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		src_idle_pct  = 24;
		sink_idle_pct = 48;
		test_directed();
		test_random(120);

		src_idle_pct  = 48;
		sink_idle_pct = 24;
		test_backpressure();
		test_random(120);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_drain_pause();
		test_random(120);

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("ordered_list_engine_tb OK");
		else
			$display("ordered_list_engine_tb NOT OK");
		$finish;
	end

endmodule
